>>> rtl/mhih_pkg.sv
package mhih_pkg;

    // datapath word of the vectoring loop: 17-bit difference, 12 fraction bits, gain headroom
    localparam int CORDIC_W  = 32;
    localparam int BIT_IDX_W = $clog2(CORDIC_W);
    localparam int PRESCALE  = 12;
    // angle in 2^-16 degree, signed, covers -100 .. +280 degrees
    localparam int ANG_W     = 26;
    localparam int TABLE_LEN = 24;
    localparam int TAB_IDX_W = 5;

    localparam logic [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);
    localparam logic [ANG_W-1:0] DEG360 = ANG_W'(360 * 65536);

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_LOCK    = 2'd1,
        OP_RESTART = 2'd2
    } opcode_t;

    localparam logic signed [15:0] AXIS_MAX = 16'sh7fff;
    localparam logic signed [15:0] AXIS_MIN = 16'sh8000;

    // atan(2^-i) in degrees, scaled by 2^16 and rounded
    function automatic logic [ANG_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
        logic [21:0] t;
        case (idx)
            5'd0:  t = 22'd2949120;
            5'd1:  t = 22'd1740967;
            5'd2:  t = 22'd919879;
            5'd3:  t = 22'd466945;
            5'd4:  t = 22'd234379;
            5'd5:  t = 22'd117304;
            5'd6:  t = 22'd58666;
            5'd7:  t = 22'd29335;
            5'd8:  t = 22'd14668;
            5'd9:  t = 22'd7334;
            5'd10: t = 22'd3667;
            5'd11: t = 22'd1833;
            5'd12: t = 22'd917;
            5'd13: t = 22'd458;
            5'd14: t = 22'd229;
            5'd15: t = 22'd115;
            5'd16: t = 22'd57;
            5'd17: t = 22'd29;
            5'd18: t = 22'd14;
            5'd19: t = 22'd7;
            5'd20: t = 22'd4;
            5'd21: t = 22'd2;
            5'd22: t = 22'd1;
            default: t = 22'd0;
        endcase
        return {{(ANG_W-22){1'b0}}, t};
    endfunction

endpackage

>>> rtl/magnetometer_hard_iron_heading.sv
// Two-axis magnetometer hard-iron calibration with heading output.
// Input channel s_*: one item per handshake; s_tuser carries the opcode
// (sample, lock, restart), s_tdata the raw x and y readings.
// Result channel m_*: exactly one item per input item, in order; m_tdata
// carries heading (1/2^HEADING_FRACTION_BITS degree) and the x and y
// offsets, m_tuser the locked flag.
// Lock, restart and unused opcodes go from S_IDLE straight to S_DONE and
// from there to the output register. A sample with a nonzero calibrated
// vector runs a bit-serial CORDIC arctangent: each of the ANGLE_ITERATIONS
// rotations streams the 32-bit x, y words and the angle through one-bit
// adders, then S_WRAP, S_ROUND and S_FOLD wrap, round and fold the angle.
// A zero vector goes straight to S_DONE.
// One item is in work at a time; the next is accepted as soon as the
// previous result has moved to the output register, even if the
// receiver has not yet taken it. While the output register is full and m_tready
// is low, a finished result waits in the core and no new item is accepted.
// Reset (aresetn low, synchronous) clears the extremes, offsets and
// locked flag to their calibration start values and empties the block.
module magnetometer_hard_iron_heading #(
    parameter int ANGLE_ITERATIONS      = 16,
    parameter int HEADING_FRACTION_BITS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_sample [15:0], y_sample [31:16]
    input  logic [1:0]  s_tuser,   // opcode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // heading [15:0], x_offset [31:16], y_offset [47:32]
    output logic [0:0]  m_tuser    // locked [0]
);
    import mhih_pkg::*;

    localparam int ITER_W = $clog2(ANGLE_ITERATIONS);
    localparam int RND_SH = 16 - HEADING_FRACTION_BITS;
    localparam logic [ANG_W-1:0] RND_HALF = ANG_W'(1) << (RND_SH - 1);
    localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(360) << HEADING_FRACTION_BITS;
    localparam int PAD_W = CORDIC_W - 17 - PRESCALE;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ITER,
        S_WRAP,
        S_ROUND,
        S_FOLD,
        S_DONE
    } state_t;

    state_t state_reg;

    logic signed [15:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic signed [15:0] x_center_reg, y_center_reg;
    logic               lock_reg;

    logic [CORDIC_W-1:0]  x_reg, y_reg, xn_reg, yn_reg;
    logic [ANG_W-1:0]     ang_reg;
    logic [BIT_IDX_W-1:0] bit_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic                 cx_reg, cy_reg, ca_reg;
    logic [15:0]          head_reg;

    logic               m_valid_reg;
    logic [47:0]        m_data_reg;
    logic               m_lock_reg;

    // input decode
    logic signed [15:0] x_in, y_in;
    logic signed [16:0] dx, dy, x_sum, y_sum, x_adj, y_adj;
    logic [CORDIC_W-1:0] x_scaled, y_scaled;
    logic               accept;

    always_comb begin
        x_in     = s_tdata[15:0];
        y_in     = s_tdata[31:16];
        dx       = 17'({x_in[15], x_in}) - 17'({x_center_reg[15], x_center_reg});
        dy       = 17'({y_in[15], y_in}) - 17'({y_center_reg[15], y_center_reg});
        x_scaled = {{PAD_W{dx[16]}}, dx, {PRESCALE{1'b0}}};
        y_scaled = {{PAD_W{dy[16]}}, dy, {PRESCALE{1'b0}}};
        x_sum    = 17'({x_high_reg[15], x_high_reg}) + 17'({x_low_reg[15], x_low_reg});
        y_sum    = 17'({y_high_reg[15], y_high_reg}) + 17'({y_low_reg[15], y_low_reg});
        // round toward zero before halving
        x_adj    = x_sum + {16'd0, x_sum[16]};
        y_adj    = y_sum + {16'd0, y_sum[16]};
        accept   = s_tvalid && (state_reg == S_IDLE);
    end

    // serial datapath
    logic [5:0]           tap_sum;
    logic [BIT_IDX_W-1:0] tap;
    logic                 y_pos, xs_bit, ys_bit, last_bit, last_iter;
    logic                 x_cin, y_cin, a_cin, x_b, y_b, a_b, t_bit;
    logic                 x_bit, y_bit, a_bit, x_co, y_co, a_co;
    logic [CORDIC_W-1:0]  t_word;

    always_comb begin
        tap_sum   = 6'(bit_reg) + 6'(iter_reg);
        tap       = (tap_sum > 6'(CORDIC_W - 1)) ? BIT_IDX_W'(CORDIC_W - 1)
                                                 : tap_sum[BIT_IDX_W-1:0];
        y_pos     = ~y_reg[CORDIC_W-1];
        xs_bit    = x_reg[tap];
        ys_bit    = y_reg[tap];
        t_word    = CORDIC_W'(atan_q16(TAB_IDX_W'(iter_reg)));
        t_bit     = t_word[bit_reg];
        last_bit  = (bit_reg == BIT_IDX_W'(CORDIC_W - 1));
        last_iter = (iter_reg == ITER_W'(ANGLE_ITERATIONS - 1));

        // subtract as add of inverted operand with carry-in set
        x_b   = y_pos ? ys_bit : ~ys_bit;
        y_b   = y_pos ? ~xs_bit : xs_bit;
        a_b   = y_pos ? t_bit : ~t_bit;
        x_cin = (bit_reg == '0) ? ~y_pos : cx_reg;
        y_cin = (bit_reg == '0) ? y_pos : cy_reg;
        a_cin = (bit_reg == '0) ? ~y_pos : ca_reg;

        x_bit = x_reg[bit_reg] ^ x_b ^ x_cin;
        x_co  = (x_reg[bit_reg] & x_b) | (x_cin & (x_reg[bit_reg] ^ x_b));
        y_bit = y_reg[bit_reg] ^ y_b ^ y_cin;
        y_co  = (y_reg[bit_reg] & y_b) | (y_cin & (y_reg[bit_reg] ^ y_b));
        a_bit = ang_reg[0] ^ a_b ^ a_cin;
        a_co  = (ang_reg[0] & a_b) | (a_cin & (ang_reg[0] ^ a_b));
    end

    logic [ANG_W-1:0] round_sum;
    assign round_sum = ang_reg + RND_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            x_low_reg    <= AXIS_MAX;
            x_high_reg   <= AXIS_MIN;
            y_low_reg    <= AXIS_MAX;
            y_high_reg   <= AXIS_MIN;
            x_center_reg <= '0;
            y_center_reg <= '0;
            lock_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        head_reg  <= '0;
                        if (s_tuser == OP_SAMPLE && (dx != '0 || dy != '0)) begin
                            state_reg <= S_ITER;
                        end else begin
                            state_reg <= S_DONE;
                        end
                        case (s_tuser)
                            OP_SAMPLE: begin
                                if (!lock_reg) begin
                                    if (x_in < x_low_reg)  x_low_reg  <= x_in;
                                    if (x_in > x_high_reg) x_high_reg <= x_in;
                                    if (y_in < y_low_reg)  y_low_reg  <= y_in;
                                    if (y_in > y_high_reg) y_high_reg <= y_in;
                                end
                                if (dx != '0 || dy != '0) begin
                                    // fold the left half plane onto the right
                                    if (dx[16]) begin
                                        x_reg   <= -x_scaled;
                                        y_reg   <= -y_scaled;
                                        ang_reg <= DEG180;
                                    end else begin
                                        x_reg   <= x_scaled;
                                        y_reg   <= y_scaled;
                                        ang_reg <= '0;
                                    end
                                    bit_reg   <= '0;
                                    iter_reg  <= '0;
                                end
                            end
                            OP_LOCK: begin
                                if (!lock_reg) begin
                                    x_center_reg <= x_adj[16:1];
                                    y_center_reg <= y_adj[16:1];
                                    lock_reg     <= 1'b1;
                                end
                            end
                            OP_RESTART: begin
                                x_low_reg    <= AXIS_MAX;
                                x_high_reg   <= AXIS_MIN;
                                y_low_reg    <= AXIS_MAX;
                                y_high_reg   <= AXIS_MIN;
                                x_center_reg <= '0;
                                y_center_reg <= '0;
                                lock_reg     <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ITER: begin
                    cx_reg <= x_co;
                    cy_reg <= y_co;
                    xn_reg <= {x_bit, xn_reg[CORDIC_W-1:1]};
                    yn_reg <= {y_bit, yn_reg[CORDIC_W-1:1]};
                    if (bit_reg < BIT_IDX_W'(ANG_W)) begin
                        ca_reg  <= a_co;
                        ang_reg <= {a_bit, ang_reg[ANG_W-1:1]};
                    end
                    bit_reg <= bit_reg + BIT_IDX_W'(1);
                    if (last_bit) begin
                        // commit the rotation once every bit is through
                        x_reg <= {x_bit, xn_reg[CORDIC_W-1:1]};
                        y_reg <= {y_bit, yn_reg[CORDIC_W-1:1]};
                        if (last_iter) begin
                            state_reg <= S_WRAP;
                        end else begin
                            iter_reg <= iter_reg + ITER_W'(1);
                        end
                    end
                end
                S_WRAP: begin
                    if (ang_reg[ANG_W-1]) begin
                        ang_reg <= ang_reg + DEG360;
                    end
                    state_reg <= S_ROUND;
                end
                S_ROUND: begin
                    ang_reg   <= round_sum >> RND_SH;
                    state_reg <= S_FOLD;
                end
                S_FOLD: begin
                    if (ang_reg >= FULL_TURN) begin
                        head_reg <= 16'(ang_reg - FULL_TURN);
                    end else begin
                        head_reg <= ang_reg[15:0];
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= {y_center_reg, x_center_reg, head_reg};
                        m_lock_reg  <= lock_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_lock_reg;

endmodule

>>> dv/tb_magnetometer_hard_iron_heading.sv
`timescale 1ns / 100ps

module tb_magnetometer_hard_iron_heading;
    import mhih_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // heading arithmetic of the block at its default parameters
    localparam int     ROTATIONS    = 16;
    localparam int     FRAC_BITS    = 7;
    localparam longint Q16_DEG360   = 64'd360 * 64'd65536;
    localparam longint Q16_DEG180   = 64'd180 * 64'd65536;
    localparam longint ATAN_DEG_Q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 3000;
    localparam int HOLD_AT      = 40;
    localparam int RANDOM_ITEMS = 1520;

    localparam int READY_ALWAYS = 0;
    localparam int READY_HALF   = 1;
    localparam int READY_SPARSE = 2;

    typedef struct packed {
        logic [1:0]          op;
        logic signed [15:0]  x;
        logic signed [15:0]  y;
    } mag_item_t;

    typedef struct packed {
        logic [15:0]         heading;
        logic                locked;
        logic signed [15:0]  x_off;
        logic signed [15:0]  y_off;
    } heading_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // x_sample [15:0], y_sample [31:16]
    logic [1:0]  s_tuser  = '0;   // opcode [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // heading [15:0], x_offset [31:16], y_offset [47:32]
    logic [0:0]  m_tuser;         // locked [0]

    mag_item_t       pending_items [$];
    heading_result_t expected_headings [$];

    // calibration state tracked alongside the block
    int  x_min_seen, x_max_seen, y_min_seen, y_max_seen;
    int  x_center, y_center;
    bit  cal_locked;

    int  mismatches = 0;
    int  results_seen = 0;

    magnetometer_hard_iron_heading dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic restart_calibration();
        x_min_seen = 32767;
        x_max_seen = -32768;
        y_min_seen = 32767;
        y_max_seen = -32768;
        x_center   = 0;
        y_center   = 0;
        cal_locked = 1'b0;
    endtask

    function automatic logic [15:0] heading_of_vector(input int dx, input int dy);
        longint x, y, ang, xs, ys, h;
        if (dx == 0 && dy == 0)
            return 16'd0;
        x   = longint'(dx) * 4096;
        y   = longint'(dy) * 4096;
        ang = 0;
        // fold the left half-plane onto the right one
        if (x < 0) begin
            x   = -x;
            y   = -y;
            ang = Q16_DEG180;
        end
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x   = x + ys;
                y   = y - xs;
                ang = ang + ATAN_DEG_Q16[i];
            end else begin
                x   = x - ys;
                y   = y + xs;
                ang = ang - ATAN_DEG_Q16[i];
            end
        end
        while (ang < 0)
            ang = ang + Q16_DEG360;
        while (ang >= Q16_DEG360)
            ang = ang - Q16_DEG360;
        h = (ang + (64'd1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
        if (h >= (longint'(360) << FRAC_BITS))
            h = h - (longint'(360) << FRAC_BITS);
        return h[15:0];
    endfunction

    task automatic predict_heading(input mag_item_t item, output heading_result_t res);
        int xs, ys;
        xs = int'(item.x);
        ys = int'(item.y);
        res.heading = 16'd0;
        if (item.op == OP_SAMPLE) begin
            if (!cal_locked) begin
                if (xs < x_min_seen) x_min_seen = xs;
                if (xs > x_max_seen) x_max_seen = xs;
                if (ys < y_min_seen) y_min_seen = ys;
                if (ys > y_max_seen) y_max_seen = ys;
            end
            res.heading = heading_of_vector(xs - x_center, ys - y_center);
        end else if (item.op == OP_LOCK) begin
            if (!cal_locked) begin
                x_center   = (x_max_seen + x_min_seen) / 2;
                y_center   = (y_max_seen + y_min_seen) / 2;
                cal_locked = 1'b1;
            end
        end else if (item.op == OP_RESTART) begin
            restart_calibration();
        end
        res.locked = cal_locked;
        res.x_off  = x_center[15:0];
        res.y_off  = y_center[15:0];
    endtask

    task automatic push_item(input logic [1:0] op, input int x, input int y);
        mag_item_t item;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        item.op = op;
        item.x  = x[15:0];
        item.y  = y[15:0];
        pending_items.push_back(item);
    endtask

    function automatic int rand_span(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int rand_axis();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // sender: bursts of items separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        mag_item_t       item;
        heading_result_t res;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left = $urandom_range(1, 16);
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                item.op = s_tuser;
                item.x  = s_tdata[15:0];
                item.y  = s_tdata[31:16];
                predict_heading(item, res);
                expected_headings.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {item.y, item.x};
                    s_tuser  <= item.op;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 600)
                                                                 : $urandom_range(0, 3);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random ready pattern plus one long hold-off
    int  ready_mode  = READY_ALWAYS;
    int  mode_left   = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
                mode_left  = $urandom_range(16, 200);
            end else begin
                mode_left = mode_left - 1;
            end
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                default:      m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        heading_result_t want;
        heading_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen = results_seen + 1;
            got.heading = m_tdata[15:0];
            got.locked  = m_tuser[0];
            got.x_off   = m_tdata[31:16];
            got.y_off   = m_tdata[47:32];
            if (expected_headings.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected item: heading %0d locked %0d offsets %0d %0d",
                             got.heading, got.locked, got.x_off, got.y_off);
            end else begin
                want = expected_headings.pop_front();
                if (got.heading !== want.heading || got.locked !== want.locked ||
                    got.x_off !== want.x_off || got.y_off !== want.y_off) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("item %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 results_seen, want.heading, want.locked, want.x_off,
                                 want.y_off, got.heading, got.locked, got.x_off, got.y_off);
                end
            end
        end
    end

    // watchdog on cycles with no accepted item on either side
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int counted, n, cx, cy, r;
        restart_calibration();

        // unused code, lock with nothing sampled, lock while locked
        push_item(OP_UNUSED, 4660, -1383);
        push_item(OP_LOCK, 0, 0);
        push_item(OP_LOCK, -1, -1);
        // zero vector, wrap of 360 degrees to zero, axis extremes
        push_item(OP_SAMPLE, 0, 0);
        push_item(OP_SAMPLE, 32767, -1);
        push_item(OP_SAMPLE, 32767, -2);
        push_item(OP_SAMPLE, -32768, -32768);
        push_item(OP_SAMPLE, 32767, 32767);
        push_item(OP_SAMPLE, -32768, 0);
        push_item(OP_SAMPLE, 0, -32768);
        push_item(OP_RESTART, 32767, 32767);
        // narrow the extremes, then lock onto a nonzero center
        push_item(OP_SAMPLE, 1000, -3000);
        push_item(OP_SAMPLE, 3000, 500);
        push_item(OP_SAMPLE, -200, -1000);
        push_item(OP_SAMPLE, -3, 1);
        push_item(OP_LOCK, 0, 0);
        push_item(OP_LOCK, 0, 0);
        push_item(OP_SAMPLE, 1398, -1250);
        push_item(OP_SAMPLE, -32768, 32767);
        push_item(OP_SAMPLE, 32767, -32768);
        push_item(OP_SAMPLE, -5000, -1250);
        push_item(OP_UNUSED, -1, 0);
        push_item(OP_RESTART, 0, 0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
                // calibration session around a random hard-iron center
                cx = rand_span(20000);
                cy = rand_span(20000);
                r  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8)
                                                 : $urandom_range(1, 14000);
                push_item(OP_RESTART, rand_axis(), rand_axis());
                n = $urandom_range(2, 12);
                repeat (n) push_item(OP_SAMPLE, cx + rand_span(r), cy + rand_span(r));
                push_item(OP_LOCK, rand_axis(), rand_axis());
                counted = counted + n + 2;
                n = $urandom_range(2, 10);
                repeat (n) begin
                    if ($urandom_range(0, 15) == 0)
                        push_item(OP_LOCK, rand_axis(), rand_axis());
                    else if ($urandom_range(0, 15) == 0)
                        push_item(OP_SAMPLE, cx + rand_span(1), cy + rand_span(1));
                    else
                        push_item(OP_SAMPLE, cx + rand_span(r), cy + rand_span(r));
                end
                counted = counted + n;
            end else begin
                // noise: any opcode, full-range readings
                n = $urandom_range(1, 8);
                repeat (n) push_item(2'($urandom_range(0, 3)), rand_axis(), rand_axis());
                counted = counted + n;
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_headings.size() > 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);

        if (mismatches == 0 && expected_headings.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
